@@ hdl/polyline_length_accumulator_core_defines.svh @@
// assertion helpers used by pla_ctrl
`ifndef POLYLINE_LENGTH_ACCUMULATOR_CORE_DEFINES_SVH
`define POLYLINE_LENGTH_ACCUMULATOR_CORE_DEFINES_SVH

// clocked check, held off during reset
`define PLA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define PLA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hdl/pla_pkg.sv @@
package pla_pkg;

    localparam int COORD_W    = 16;
    localparam int LEN_W      = 32;
    localparam int CNT_W      = 16;
    // magnitude of a coordinate difference needs one more bit
    localparam int MAG_W      = COORD_W + 1;
    localparam int ROOT_STEPS = MAG_W;
    localparam int RAD_W      = 2 * ROOT_STEPS;
    localparam int REM_W      = ROOT_STEPS + 1;
    localparam int STEP_W     = $clog2(ROOT_STEPS);

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic                      last_point;
    } t_point;

    typedef struct packed {
        logic [LEN_W-1:0] total_length;
        logic [CNT_W-1:0] segment_count;
    } t_result;

    typedef struct packed {
        logic load;
        logic sq_x;
        logic sq_y;
        logic step;
        logic acc;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic have_prev;
        logic last;
        logic out_free;
    } t_sts;

endpackage

@@ hdl/pla_dp.sv @@
module pla_dp
    import pla_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    output t_sts    o_sts,
    input  t_point  i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_out_data
);

    logic signed [COORD_W-1:0] r_prev_x, r_prev_y;
    logic                      r_have_prev;
    logic                      r_last;
    logic [MAG_W-1:0]          r_dx, r_dy;
    logic [RAD_W-1:0]          r_rad;
    logic [REM_W-1:0]          r_rem;
    logic [ROOT_STEPS-1:0]     r_root;
    logic [LEN_W-1:0]          r_sum;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_out_valid;
    t_result                   r_out;

    logic signed [MAG_W-1:0] diff_x, diff_y;
    logic [MAG_W-1:0]        mag_x, mag_y;
    logic [MAG_W-1:0]        mul_op;
    logic [RAD_W-1:0]        product;
    logic [REM_W+1:0]        rem_sh, trial, rem_sub;
    logic [LEN_W:0]          sum_ext;

    always_comb begin
        diff_x = MAG_W'(i_in_data.x_coord) - MAG_W'(r_prev_x);
        diff_y = MAG_W'(i_in_data.y_coord) - MAG_W'(r_prev_y);
        mag_x  = diff_x[MAG_W-1] ? MAG_W'(-diff_x) : MAG_W'(diff_x);
        mag_y  = diff_y[MAG_W-1] ? MAG_W'(-diff_y) : MAG_W'(diff_y);
        // one multiplier, shared between the two squares
        mul_op  = i_cmd.sq_x ? r_dx : r_dy;
        product = RAD_W'(mul_op) * RAD_W'(mul_op);
        // one result bit per step, two radicand bits shifted in
        rem_sh  = {r_rem, r_rad[RAD_W-1 -: 2]};
        trial   = (REM_W+2)'({r_root, 2'b01});
        rem_sub = rem_sh - trial;
        sum_ext = (LEN_W+1)'(r_sum) + (LEN_W+1)'(r_root);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_have_prev <= 1'b0;
            r_last      <= 1'b0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_dx        <= mag_x;
                r_dy        <= mag_y;
                r_prev_x    <= i_in_data.x_coord;
                r_prev_y    <= i_in_data.y_coord;
                r_last      <= i_in_data.last_point;
                r_have_prev <= 1'b1;
            end
            if (i_cmd.sq_x) begin
                r_rad <= product;
            end
            if (i_cmd.sq_y) begin
                r_rad  <= r_rad + product;
                r_rem  <= '0;
                r_root <= '0;
            end
            if (i_cmd.step) begin
                r_rad <= {r_rad[RAD_W-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sub[REM_W-1:0];
                    r_root <= {r_root[ROOT_STEPS-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh[REM_W-1:0];
                    r_root <= {r_root[ROOT_STEPS-2:0], 1'b0};
                end
            end
            if (i_cmd.acc) begin
                r_sum <= sum_ext[LEN_W] ? '1 : sum_ext[LEN_W-1:0];
                if (r_cnt != '1) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            if (i_cmd.emit) begin
                r_out.total_length  <= r_sum;
                r_out.segment_count <= r_cnt;
                r_out_valid         <= 1'b1;
                // path done, start clean
                r_sum       <= '0;
                r_cnt       <= '0;
                r_prev_x    <= '0;
                r_prev_y    <= '0;
                r_have_prev <= 1'b0;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.have_prev = r_have_prev;
    assign o_sts.last      = r_last;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule

@@ hdl/pla_ctrl.sv @@
`include "polyline_length_accumulator_core_defines.svh"

module pla_ctrl
    import pla_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_ROOT,
        S_ACC,
        S_FIN
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    // first point of a path has no segment
                    n_state = i_sts.have_prev ? S_SQX : S_FIN;
                end
            end
            S_SQX: begin
                o_cmd.sq_x = 1'b1;
                n_state    = S_SQY;
            end
            S_SQY: begin
                o_cmd.sq_y = 1'b1;
                n_step     = STEP_W'(ROOT_STEPS - 1);
                n_state    = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.step = 1'b1;
                if (r_step == '0) begin
                    n_state = S_ACC;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (!i_sts.last) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    `PLA_ASSERT(a_one_cmd, $onehot0(o_cmd), "more than one datapath command at once")
    `PLA_ASSERT(a_emit_free, o_cmd.emit |-> i_sts.out_free, "result written over a pending one")
    `PLA_ASSERT(a_root_done, (r_state == S_ROOT && r_step == '0) |=> r_state == S_ACC, "root steps miscounted")
    `PLA_ASSERT(a_load_idle, o_cmd.load |-> !o_in_stall, "point loaded without a transfer")

endmodule

@@ hdl/polyline_length_accumulator_core.sv @@
// polyline length accumulator
// input channel: i_in_valid / o_in_stall carry one point (signed q8.8 x and y,
//   plus a last-point flag); a transfer happens when valid is high and stall low
// output channel: o_out_valid / i_out_stall carry one result per path, the total
//   length (unsigned q24.8, saturating) and the segment count (saturating)
// each point after the first of a path adds the truncated root of dx^2 + dy^2
// a point with a predecessor goes from its transfer to the next possible transfer
//   through S_SQX and S_SQY (two squares on the shared multiplier), S_ROOT (the
//   bit-serial square root, 17 result bits), S_ACC, S_FIN and back to S_IDLE
// the first point of a path goes from S_IDLE straight to S_FIN
// the result of a last point is written to the output register in S_FIN, and
//   the path state clears with it for the next path
// a finished result sits in an output register, so the next path can start
//   while it waits; a last point whose result finds that register still held
//   waits in the finish step until the receiver takes the earlier result
// reset clears the path state and drops any pending result
module polyline_length_accumulator_core
    import pla_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_point  i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_out_data
);

    t_cmd cmd;
    t_sts sts;

    pla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pla_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

@@ verif/tb_polyline_length_accumulator_core.sv @@
module tb_polyline_length_accumulator_core;
    import pla_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_POINTS   = 650;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int ROOT_TOP_BIT   = 17;

    typedef enum int {
        SPAN_ANY,
        SPAN_NEAR,
        SPAN_CORNER
    } t_span;

    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    i_in_valid  = 1'b0;
    logic    o_in_stall;
    t_point  i_in_data   = '0;
    logic    o_out_valid;
    logic    i_out_stall = 1'b0;
    t_result o_out_data;

    int send_idle_pct = 27;
    int recv_idle_pct = 53;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    // path state of the predictor
    logic signed [COORD_W-1:0] prev_x    = '0;
    logic signed [COORD_W-1:0] prev_y    = '0;
    logic                      have_prev = 1'b0;
    logic [LEN_W-1:0]          len_sum   = '0;
    logic [CNT_W-1:0]          seg_count = '0;

    t_result paths_due[$];
    t_result want;

    polyline_length_accumulator_core dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // truncated square root of dx^2 + dy^2
    function automatic longint unsigned segment_length(input longint dx, input longint dy);
        longint unsigned radicand;
        longint unsigned root;
        longint unsigned trial;
        radicand = dx * dx + dy * dy;
        root = 0;
        for (int b = ROOT_TOP_BIT; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic void advance_path(input t_point pt);
        longint unsigned grown;
        if (have_prev) begin
            grown = 64'(len_sum) + segment_length(longint'(pt.x_coord) - longint'(prev_x),
                                                  longint'(pt.y_coord) - longint'(prev_y));
            len_sum = (grown > 64'hFFFF_FFFF) ? '1 : LEN_W'(grown);
            if (seg_count != '1) begin
                seg_count = seg_count + 1'b1;
            end
        end
        prev_x    = pt.x_coord;
        prev_y    = pt.y_coord;
        have_prev = 1'b1;
        if (pt.last_point) begin
            paths_due.push_back('{total_length: len_sum, segment_count: seg_count});
            prev_x    = '0;
            prev_y    = '0;
            have_prev = 1'b0;
            len_sum   = '0;
            seg_count = '0;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            advance_path(i_in_data);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (paths_due.size() == 0) begin
                $display("%0t: unexpected path result, expected none, got length %0d count %0d",
                         $time, o_out_data.total_length, o_out_data.segment_count);
                mismatches++;
            end else begin
                want = paths_due.pop_front();
                if (o_out_data.total_length !== want.total_length) begin
                    $display("%0t: total_length mismatch, expected %0d, got %0d",
                             $time, want.total_length, o_out_data.total_length);
                    mismatches++;
                end
                if (o_out_data.segment_count !== want.segment_count) begin
                    $display("%0t: segment_count mismatch, expected %0d, got %0d",
                             $time, want.segment_count, o_out_data.segment_count);
                    mismatches++;
                end
            end
        end
    end

    // cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_point make_point(input int x, input int y, input bit last);
        t_point pt;
        pt.x_coord    = COORD_W'(x);
        pt.y_coord    = COORD_W'(y);
        pt.last_point = last;
        return pt;
    endfunction

    function automatic logic signed [COORD_W-1:0] next_coord(
        input logic signed [COORD_W-1:0] from,
        input t_span span
    );
        logic signed [COORD_W-1:0] picked;
        case (span)
            SPAN_NEAR: begin
                picked = from + COORD_W'($urandom_range(1023)) - COORD_W'(512);
            end
            SPAN_CORNER: begin
                case ($urandom_range(3))
                    0:       picked = {1'b1, {(COORD_W-1){1'b0}}};
                    1:       picked = {1'b0, {(COORD_W-1){1'b1}}};
                    2:       picked = '0;
                    default: picked = '1;
                endcase
            end
            default: begin
                picked = COORD_W'($urandom());
            end
        endcase
        return picked;
    endfunction

    task automatic send_point(input t_point pt);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= pt;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_for_paths();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (paths_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_single_point_paths();
        send_point(make_point(-32768, -32768, 1'b1));
        send_point(make_point(32767, 32767, 1'b1));
        send_point(make_point(0, 0, 1'b1));
    endtask

    task automatic test_extreme_spans();
        send_point(make_point(-32768, -32768, 1'b0));
        send_point(make_point(32767, 32767, 1'b0));
        send_point(make_point(32767, -32768, 1'b0));
        send_point(make_point(-32768, 32767, 1'b1));
    endtask

    task automatic test_short_segments();
        // zero length, a 3-4-5 triangle, then roots that truncate
        send_point(make_point(0, 0, 1'b0));
        send_point(make_point(0, 0, 1'b0));
        send_point(make_point(768, 1024, 1'b0));
        send_point(make_point(769, 1025, 1'b0));
        send_point(make_point(-256, -256, 1'b0));
        send_point(make_point(-255, -256, 1'b1));
    endtask

    task automatic test_random_paths(input int n_points, input int send_pct, input int recv_pct);
        int     sent;
        int     run;
        t_span  span;
        t_point pt;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        pt = '0;
        while (sent < n_points) begin
            run  = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 24);
            span = t_span'($urandom_range(SPAN_CORNER));
            for (int k = 0; k < run; k++) begin
                pt.x_coord    = next_coord(pt.x_coord, span);
                pt.y_coord    = next_coord(pt.y_coord, span);
                pt.last_point = (k == run - 1);
                send_point(pt);
            end
            sent += run;
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_single_point_paths();
        test_extreme_spans();
        test_short_segments();
        test_random_paths(PHASE_POINTS, 27, 53);
        wait_for_paths();
        test_random_paths(PHASE_POINTS, 53, 27);
        test_random_paths(PHASE_POINTS, 0, 0);

        wait_for_paths();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && paths_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/pla_pkg.sv
hdl/pla_dp.sv
hdl/pla_ctrl.sv
hdl/polyline_length_accumulator_core.sv
verif/tb_polyline_length_accumulator_core.sv
